@@ rtl/ffha_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared sizes, tag layout, status codes and controller/datapath interface
// types for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int HEAP_PAGES    = 64;
  localparam int PAGE_BYTES    = 4096;
  localparam int TAG_BYTES     = 16;
  localparam int GRANULE_BYTES = 32;

  localparam int HEAP_BYTES = HEAP_PAGES * PAGE_BYTES;
  localparam int SLOTS      = HEAP_BYTES / TAG_BYTES;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int TAG_LSB    = $clog2(TAG_BYTES);
  localparam int PAGE_LSB   = $clog2(PAGE_BYTES);
  localparam int GRAN_LSB   = $clog2(GRANULE_BYTES);
  localparam int POS_W      = $clog2(HEAP_BYTES + 1);
  localparam int LEN_W      = $clog2(HEAP_BYTES);
  localparam int PAGES_W    = $clog2(HEAP_PAGES + 1);
  localparam int PAGE_FREE  = PAGE_BYTES - TAG_BYTES;

  // Request and result field widths
  localparam int FUNC_W   = 1;
  localparam int REQ_W    = 19;
  localparam int OFF_W    = 18;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 19;
  localparam int NEED_W   = REQ_W + 1;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OOM     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

  // One block tag
  typedef struct packed {
    logic             used;
    logic [LEN_W-1:0] len;
  } tag_t;

  localparam tag_t INIT_TAG = '{used: 1'b0, len: LEN_W'(PAGE_FREE)};

  // Datapath commands
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RESTART,
    OP_RD_CUR,
    OP_RD_NXT,
    OP_CAP_CUR,
    OP_CAP_NXT,
    OP_STEP,
    OP_SHIFT,
    OP_MERGE,
    OP_SPLIT_HEAD,
    OP_SPLIT_TAIL,
    OP_ADD_PAGE,
    OP_FREE
  } dp_op_t;

  // Datapath status flags
  typedef struct packed {
    logic at_end;
    logic nxt_is_end;
    logic cur_fit;
    logic cur_used;
    logic merge_ok;
    logic can_grow;
    logic free_hit;
    logic free_past;
    logic in_off_null;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ rtl/ffha_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_dp
// Allocator datapath: tag memory indexed by block address, chain walk
// position, current/next tag registers and the running byte totals.
// ----------------------------------------------------------------------------
module ffha_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ffha_pkg::dp_op_t              op,
  input  wire logic [ffha_pkg::REQ_W-1:0]    request_bytes,
  input  wire logic [ffha_pkg::OFF_W-1:0]    block_offset,
  output ffha_pkg::dp_stat_t                 stat,
  output logic      [ffha_pkg::OFF_W-1:0]    result_offset,
  output logic      [ffha_pkg::TOTAL_W-1:0]  available_bytes,
  output logic      [ffha_pkg::TOTAL_W-1:0]  used_bytes
);
  import ffha_pkg::*;

  tag_t                mem [SLOTS];
  tag_t                mem_q;
  logic                rd_zero;
  logic                slot0_wr;

  logic [POS_W-1:0]    pos;
  tag_t                cur;
  tag_t                nxt;
  logic [NEED_W-1:0]   need;
  logic [OFF_W-1:0]    off;
  logic [PAGES_W-1:0]  pages;
  logic [TOTAL_W-1:0]  free_total;
  logic [TOTAL_W-1:0]  used_total;
  logic [OFF_W-1:0]    result;

  logic [POS_W-1:0]    heap_end;
  logic [POS_W-1:0]    step_pos;
  logic [POS_W-1:0]    rem_pos;
  logic [LEN_W-1:0]    rem_len;
  logic [LEN_W-1:0]    merged_len;
  logic [NEED_W:0]     need_tag;
  logic [NEED_W-1:0]   need_raw;
  logic [NEED_W-1:0]   need_round;
  logic [POS_W:0]      pos_payload;
  tag_t                rdata;

  logic                we;
  logic [SLOT_W-1:0]   waddr;
  tag_t                wdata;
  logic                re;
  logic [SLOT_W-1:0]   raddr;

  // Chain arithmetic
  assign heap_end    = POS_W'({pages, {PAGE_LSB{1'b0}}});
  assign step_pos    = pos + POS_W'(cur.len) + POS_W'(TAG_BYTES);
  assign need_tag    = (NEED_W+1)'(need) + (NEED_W+1)'(TAG_BYTES);
  assign rem_pos     = pos + POS_W'(TAG_BYTES) + POS_W'(need);
  assign rem_len     = cur.len - LEN_W'(need) - LEN_W'(TAG_BYTES);
  assign merged_len  = cur.len + nxt.len + LEN_W'(TAG_BYTES);
  assign pos_payload = (POS_W+1)'(pos) + (POS_W+1)'(TAG_BYTES);
  assign need_raw    = NEED_W'(request_bytes) + NEED_W'(GRANULE_BYTES - 1);
  assign need_round  = {need_raw[NEED_W-1:GRAN_LSB], {GRAN_LSB{1'b0}}};

  // Slot 0 reads as the initial page tag until first written
  assign rdata = (rd_zero && !slot0_wr) ? INIT_TAG : mem_q;

  // Status to controller
  always_comb begin
    stat.at_end      = (pos == heap_end);
    stat.nxt_is_end  = (step_pos == heap_end);
    stat.cur_fit     = !cur.used && ((NEED_W+1)'(cur.len) >= need_tag);
    stat.cur_used    = cur.used;
    stat.merge_ok    = !cur.used && !nxt.used;
    stat.can_grow    = (pages < PAGES_W'(HEAP_PAGES));
    stat.free_hit    = (pos_payload == (POS_W+1)'(off));
    stat.free_past   = (pos_payload > (POS_W+1)'(off));
    stat.in_off_null = (block_offset == '0);
  end

  // Memory port control
  always_comb begin
    we    = 1'b0;
    waddr = pos[TAG_LSB +: SLOT_W];
    wdata = cur;
    re    = 1'b0;
    raddr = pos[TAG_LSB +: SLOT_W];
    unique case (op)
      OP_RD_CUR: re = 1'b1;
      OP_RD_NXT: begin
        re    = 1'b1;
        raddr = step_pos[TAG_LSB +: SLOT_W];
      end
      OP_MERGE: begin
        we    = 1'b1;
        wdata = '{used: 1'b0, len: merged_len};
      end
      OP_SPLIT_HEAD: begin
        we    = 1'b1;
        wdata = '{used: 1'b1, len: LEN_W'(need)};
      end
      OP_SPLIT_TAIL: begin
        we    = 1'b1;
        waddr = rem_pos[TAG_LSB +: SLOT_W];
        wdata = '{used: 1'b0, len: rem_len};
      end
      OP_ADD_PAGE: begin
        we    = 1'b1;
        waddr = heap_end[TAG_LSB +: SLOT_W];
        wdata = INIT_TAG;
      end
      OP_FREE: begin
        we    = 1'b1;
        wdata = '{used: 1'b0, len: cur.len};
      end
      default: ;
    endcase
  end

  // Tag memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      mem_q   <= mem[raddr];
      rd_zero <= (raddr == '0);
    end
  end

  // Control registers: totals, page count, slot 0 written flag
  always_ff @(posedge clk) begin
    if (rst) begin
      pages      <= PAGES_W'(1);
      free_total <= TOTAL_W'(PAGE_FREE);
      used_total <= '0;
      slot0_wr   <= 1'b0;
    end else begin
      if (we && waddr == '0) begin
        slot0_wr <= 1'b1;
      end
      unique case (op)
        OP_SPLIT_HEAD: begin
          free_total <= free_total - TOTAL_W'(need_tag);
          used_total <= used_total + TOTAL_W'(need_tag);
        end
        OP_ADD_PAGE: begin
          pages      <= pages + PAGES_W'(1);
          free_total <= free_total + TOTAL_W'(PAGE_FREE);
        end
        OP_FREE: begin
          free_total <= free_total + TOTAL_W'(cur.len) + TOTAL_W'(TAG_BYTES);
          used_total <= used_total - TOTAL_W'(cur.len) - TOTAL_W'(TAG_BYTES);
        end
        default: ;
      endcase
    end
  end

  // Walk registers
  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: begin
        pos    <= '0;
        need   <= need_round;
        off    <= block_offset;
        result <= '0;
      end
      OP_RESTART:    pos <= '0;
      OP_CAP_CUR:    cur <= rdata;
      OP_CAP_NXT:    nxt <= rdata;
      OP_STEP:       pos <= step_pos;
      OP_SHIFT: begin
        pos <= step_pos;
        cur <= nxt;
      end
      OP_MERGE:      cur.len <= merged_len;
      OP_SPLIT_HEAD: result  <= OFF_W'(pos_payload);
      OP_ADD_PAGE:   pos     <= '0;
      default: ;
    endcase
  end

  assign result_offset   = result;
  assign available_bytes = free_total;
  assign used_bytes      = used_total;

  // Checks
  a_pages_max : assert property (@(posedge clk) disable iff (rst)
    pages <= PAGES_W'(HEAP_PAGES))
    else $error("page count beyond heap size");

  a_bytes_kept : assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> (TOTAL_W'(free_total + used_total) ==
                     TOTAL_W'(32'(pages) * PAGE_FREE)))
    else $error("free plus used bytes do not match committed pages");

  a_pos_in_heap : assert property (@(posedge clk) disable iff (rst)
    (op == OP_STEP || op == OP_SHIFT) |=> pos <= heap_end)
    else $error("chain walk left the committed heap");

endmodule
`default_nettype wire

@@ rtl/ffha_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_ctrl
// Allocator sequencer: chain walk for allocate and free, page growth,
// coalescing pass, and result handshake.
// ----------------------------------------------------------------------------
module ffha_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic [ffha_pkg::FUNC_W-1:0]   func,
  output logic                               in_stall,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [ffha_pkg::STATUS_W-1:0] status,
  output ffha_pkg::dp_op_t                   op,
  input  wire ffha_pkg::dp_stat_t            stat
);
  import ffha_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_RD,
    S_A_WAIT,
    S_A_CHK,
    S_A_TAIL,
    S_GROW,
    S_C_RD,
    S_C_WAIT,
    S_C_NX,
    S_C_NWAIT,
    S_C_CHK,
    S_F_RD,
    S_F_WAIT,
    S_F_CHK,
    S_RESP
  } state_t;

  state_t                state;
  state_t                state_next;
  logic [STATUS_W-1:0]   status_next;

  // Next state and datapath command
  always_comb begin
    state_next  = state;
    status_next = status;
    op          = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op = OP_LOAD;
          if (func == FUNC_ALLOC) begin
            state_next = S_A_RD;
          end else if (stat.in_off_null) begin
            status_next = ST_IGNORED;
            state_next  = S_RESP;
          end else begin
            state_next = S_F_RD;
          end
        end
      end
      S_A_RD: begin
        if (stat.at_end) begin
          if (stat.can_grow) begin
            state_next = S_GROW;
          end else begin
            status_next = ST_OOM;
            state_next  = S_RESP;
          end
        end else begin
          op         = OP_RD_CUR;
          state_next = S_A_WAIT;
        end
      end
      S_A_WAIT: begin
        op         = OP_CAP_CUR;
        state_next = S_A_CHK;
      end
      S_A_CHK: begin
        if (stat.cur_fit) begin
          op         = OP_SPLIT_HEAD;
          state_next = S_A_TAIL;
        end else begin
          op         = OP_STEP;
          state_next = S_A_RD;
        end
      end
      S_A_TAIL: begin
        op          = OP_SPLIT_TAIL;
        status_next = ST_OK;
        state_next  = S_RESP;
      end
      S_GROW: begin
        op         = OP_ADD_PAGE;
        state_next = S_C_RD;
      end
      // Coalescing pass from the heap start
      S_C_RD: begin
        op         = OP_RD_CUR;
        state_next = S_C_WAIT;
      end
      S_C_WAIT: begin
        op         = OP_CAP_CUR;
        state_next = S_C_NX;
      end
      S_C_NX: begin
        if (stat.nxt_is_end) begin
          op         = OP_RESTART;
          state_next = S_A_RD;
        end else begin
          op         = OP_RD_NXT;
          state_next = S_C_NWAIT;
        end
      end
      S_C_NWAIT: begin
        op         = OP_CAP_NXT;
        state_next = S_C_CHK;
      end
      S_C_CHK: begin
        op         = stat.merge_ok ? OP_MERGE : OP_SHIFT;
        state_next = S_C_NX;
      end
      // Free: find the block whose payload starts at the offset
      S_F_RD: begin
        if (stat.at_end || stat.free_past) begin
          status_next = ST_IGNORED;
          state_next  = S_RESP;
        end else begin
          op         = OP_RD_CUR;
          state_next = S_F_WAIT;
        end
      end
      S_F_WAIT: begin
        op         = OP_CAP_CUR;
        state_next = S_F_CHK;
      end
      S_F_CHK: begin
        if (stat.free_hit) begin
          if (stat.cur_used) begin
            op          = OP_FREE;
            status_next = ST_OK;
          end else begin
            status_next = ST_IGNORED;
          end
          state_next = S_RESP;
        end else begin
          op         = OP_STEP;
          state_next = S_F_RD;
        end
      end
      S_RESP: begin
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      status    <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      status    <= status_next;
      out_valid <= (state_next == S_RESP);
    end
  end

  assign in_stall = (state != S_IDLE);

  // Checks
  a_valid_state : assert property (@(posedge clk) disable iff (rst)
    out_valid == (state == S_RESP))
    else $error("result valid out of step with state");

  a_one_side : assert property (@(posedge clk) disable iff (rst)
    !(out_valid && !in_stall))
    else $error("request taken while result pending");

  a_oom_no_grow : assert property (@(posedge clk) disable iff (rst)
    (state == S_A_RD && stat.at_end && !stat.can_grow) |=> status == ST_OOM)
    else $error("exhausted heap not reported");

endmodule
`default_nettype wire

@@ rtl/first_fit_heap_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Free walks the chain block by block up to the target block.
// Allocate walks the chain block by block; each page grown is followed by a
// coalescing pass that merges or steps over the blocks from the heap start, then the
// walk restarts. One request at a time; the tag memory sets the pace.
// Reset (synchronous) leaves one committed free page and zero used bytes.
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator over an address-ordered chain of block tags with
// page growth and coalescing on demand.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [ffha_pkg::FUNC_W-1:0]   func,
  input  wire logic [ffha_pkg::REQ_W-1:0]    request_bytes,
  input  wire logic [ffha_pkg::OFF_W-1:0]    block_offset,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [ffha_pkg::STATUS_W-1:0] status,
  output logic      [ffha_pkg::OFF_W-1:0]    result_offset,
  output logic      [ffha_pkg::TOTAL_W-1:0]  available_bytes,
  output logic      [ffha_pkg::TOTAL_W-1:0]  used_bytes
);
  import ffha_pkg::*;

  dp_op_t   op;
  dp_stat_t stat;

  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .func      (func),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .op        (op),
    .stat      (stat)
  );

  ffha_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .op              (op),
    .request_bytes   (request_bytes),
    .block_offset    (block_offset),
    .stat            (stat),
    .result_offset   (result_offset),
    .available_bytes (available_bytes),
    .used_bytes      (used_bytes)
  );

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// First-fit heap allocator testbench
// Drives allocate and free requests through the valid/stall handshake, keeps
// its own copy of the block tag chain to predict each result, and compares
// every result field by field in a small scoreboard. Idling on both sides
// varies over several phases.
// ----------------------------------------------------------------------------
module testbench;
  import ffha_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OFF_W-1:0]    offset;
    logic [TOTAL_W-1:0]  avail;
    logic [TOTAL_W-1:0]  used;
  } alloc_result_t;

  // Pending allocator results, oldest first
  class alloc_scoreboard;
    alloc_result_t pending[$];
    int            errors = 0;

    task report(string what, int unsigned got, int unsigned want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
    endtask

    function void note_request(alloc_result_t r);
      pending.push_back(r);
    endfunction

    task check_result(alloc_result_t got);
      alloc_result_t want;
      if (pending.size() == 0) begin
        report("unexpected result", got.status, 0);
      end else begin
        want = pending.pop_front();
        if (got.status != want.status) report("status", got.status, want.status);
        if (got.offset != want.offset) report("result_offset", got.offset, want.offset);
        if (got.avail != want.avail) report("available_bytes", got.avail, want.avail);
        if (got.used != want.used) report("used_bytes", got.used, want.used);
      end
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [FUNC_W-1:0]   func = FUNC_ALLOC;
  logic [REQ_W-1:0]    request_bytes = '0;
  logic [OFF_W-1:0]    block_offset = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [OFF_W-1:0]    result_offset;
  logic [TOTAL_W-1:0]  available_bytes;
  logic [TOTAL_W-1:0]  used_bytes;

  first_fit_heap_allocator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .request_bytes(request_bytes), .block_offset(block_offset),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .result_offset(result_offset),
    .available_bytes(available_bytes), .used_bytes(used_bytes)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  alloc_scoreboard sb = new();

  // Shadow tag chain
  int unsigned blk_len[$];
  bit          blk_used[$];
  int unsigned pages_used;
  int unsigned free_bytes;
  int unsigned used_total;
  int unsigned live_offsets[$];
  int unsigned last_freed;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function void shadow_reset();
    blk_len = {PAGE_FREE};
    blk_used = {1'b0};
    pages_used = 1;
    free_bytes = PAGE_FREE;
    used_total = 0;
    live_offsets = {};
    last_freed = 16;
  endfunction

  function void merge_free_runs();
    int unsigned i;
    i = 0;
    while (i + 1 < blk_len.size()) begin
      if (!blk_used[i] && !blk_used[i+1]) begin
        blk_len[i] = blk_len[i] + TAG_BYTES + blk_len[i+1];
        blk_len.delete(i + 1);
        blk_used.delete(i + 1);
      end else begin
        i++;
      end
    end
  endfunction

  function int unsigned first_fit(int unsigned need);
    int unsigned pos, i, rest;
    pos = 0;
    for (i = 0; i < blk_len.size(); i++) begin
      if (!blk_used[i] && blk_len[i] >= need + TAG_BYTES && blk_len.size() < SLOTS) begin
        rest = blk_len[i] - need - TAG_BYTES;
        blk_len[i] = need;
        blk_used[i] = 1'b1;
        blk_len.insert(i + 1, rest);
        blk_used.insert(i + 1, 1'b0);
        free_bytes -= need + TAG_BYTES;
        used_total += need + TAG_BYTES;
        return pos + TAG_BYTES;
      end
      pos += blk_len[i] + TAG_BYTES;
    end
    return 0;
  endfunction

  // Expected result of one accepted request; updates the shadow state
  function alloc_result_t predict_heap(logic [FUNC_W-1:0] f, int unsigned req,
                                       int unsigned off);
    alloc_result_t r;
    int unsigned need, res, pos, i, idx;
    r.status = ST_OK;
    res = 0;
    if (f == FUNC_ALLOC) begin
      need = (req + GRANULE_BYTES - 1) / GRANULE_BYTES * GRANULE_BYTES;
      forever begin
        res = first_fit(need);
        if (res != 0) break;
        if (pages_used >= HEAP_PAGES || blk_len.size() >= SLOTS) begin
          r.status = ST_OOM;
          break;
        end
        blk_len.push_back(PAGE_FREE);
        blk_used.push_back(1'b0);
        pages_used++;
        free_bytes += PAGE_FREE;
        merge_free_runs();
      end
      if (res != 0) live_offsets.push_back(res);
    end else if (off == 0) begin
      r.status = ST_IGNORED;
    end else begin
      r.status = ST_IGNORED;
      pos = 0;
      for (i = 0; i < blk_len.size(); i++) begin
        if (pos + TAG_BYTES == off) begin
          if (blk_used[i]) begin
            blk_used[i] = 1'b0;
            used_total -= blk_len[i] + TAG_BYTES;
            free_bytes += blk_len[i] + TAG_BYTES;
            r.status = ST_OK;
            for (idx = 0; idx < live_offsets.size(); idx++)
              if (live_offsets[idx] == off) begin
                live_offsets.delete(idx);
                break;
              end
            last_freed = off;
          end
          break;
        end
        pos += blk_len[i] + TAG_BYTES;
      end
    end
    r.offset = OFF_W'(res);
    r.avail = TOTAL_W'(free_bytes);
    r.used = TOTAL_W'(used_total);
    return r;
  endfunction

  // Drive one request; valid stays high on return
  task send_request(logic [FUNC_W-1:0] f, int unsigned req, int unsigned off);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    request_bytes <= REQ_W'(req);
    block_offset <= OFF_W'(off);
    do @(posedge clk); while (in_stall);
    sb.note_request(predict_heap(f, req, off));
  endtask

  task alloc_req(int unsigned req);
    send_request(FUNC_ALLOC, req, $urandom_range(0, 262143));
  endtask

  task free_req(int unsigned off);
    send_request(FUNC_FREE, $urandom_range(0, 262144), off);
  endtask

  task drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task random_request();
    int unsigned pick, sel;
    pick = $urandom_range(99);
    if (live_offsets.size() > 30) pick = 60;
    if (pick < 55) begin
      sel = $urandom_range(99);
      if (sel < 90) alloc_req($urandom_range(0, 2048));
      else if (sel < 98) alloc_req($urandom_range(2049, 20000));
      else alloc_req($urandom_range(200000, 262144));
    end else if (pick < 90 && live_offsets.size() != 0) begin
      free_req(live_offsets[$urandom_range(0, live_offsets.size() - 1)]);
    end else begin
      sel = $urandom_range(2);
      if (sel == 0) free_req(0);
      else if (sel == 1) free_req(last_freed);
      else free_req($urandom_range(1, 262143));
    end
  endtask

  // Result side: random stall, check on handshake
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result('{status, result_offset, available_bytes, used_bytes});
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    #100_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int n, ph;
    shadow_reset();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: exact fit, tiny sizes, rounding, null/stray/double free, exhaustion
    alloc_req(4064);
    alloc_req(0);
    alloc_req(1);
    alloc_req(31);
    alloc_req(32);
    alloc_req(33);
    free_req(0);
    free_req(5);
    free_req(262143);
    free_req(live_offsets[0]);
    free_req(last_freed);
    alloc_req(262144);
    alloc_req(262143);
    alloc_req(20000);
    alloc_req(131071);
    alloc_req(0);
    while (live_offsets.size() != 0) free_req(live_offsets[0]);
    alloc_req(100);
    free_req(last_freed + 48);
    alloc_req(262144);
    drain();

    // Random phases of idling
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 54; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 54; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      for (n = 0; n < 210; n++) random_request();
      if (ph == 1) drain();
    end
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
